>>> rtl/core/fbrc_pkg.sv
// ---------------------------------------------------------------------------
// fbrc_pkg: shared definitions for the frequency-based replacement core
// Widths, defaults, register indexes and the sequencer state type.
// ---------------------------------------------------------------------------
package fbrc_pkg;

   localparam int ENTRIES_DEFAULT    = 16;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int FD_W   = 16;
   localparam int BN_W   = 31;
   localparam int KEY_W  = FD_W + BN_W;
   localparam int SLOT_W = 4;
   localparam int CFG_W  = 5;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 2;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NEW_SECTION = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OLD_SECTION = 1'b1;

   localparam logic [CFG_W-1:0] NEW_SECTION_RESET = 5'd4;
   localparam logic [CFG_W-1:0] OLD_SECTION_RESET = 5'd8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ORD,
      ST_KEY,
      ST_CMP,
      ST_DEC,
      ST_SH_RD,
      ST_SH_WR,
      ST_TAIL,
      ST_OUT
   } state_type;

endpackage

>>> rtl/core/frequency_based_cache_replacement_core.sv
// ---------------------------------------------------------------------------
// frequency_based_cache_replacement_core
// Block cache directory with frequency-based replacement over a recency list.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one access (descriptor, block number). rsp_* returns one
//   result per access: hit / evicted flags in tuser, slot and evicted key in
//   tdata. csr_* writes the new and old section sizes; always ready.
// Structure: keys, counts and the recency list sit in single-port-read memories
//   with a registered read. The search walks each list position through an
//   order read, a key/count read and a compare; the list update moves each
//   entry with an order read and an order write.
// One access is in work at a time; req_tready is high only when idle. The
//   result sits in an output register, so a new access may start while the
//   previous result waits on rsp_tready; a stalled receiver only holds the
//   finished access in its last cycle.
// Reset empties the directory (occupied count to zero) and sets the section
//   sizes to 4 and 8. No clearing pass is needed.
// ---------------------------------------------------------------------------
module frequency_based_cache_replacement_core #(
   parameter int ENTRIES    = fbrc_pkg::ENTRIES_DEFAULT,
   parameter int COUNT_BITS = fbrc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [15:0] file_descriptor, [46:16] block_number, [47] zero
   input  logic [fbrc_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [3:0] slot, [19:4] evicted_descriptor, [50:20] evicted_block, [55:51] zero
   output logic [fbrc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] hit, [1] evicted
   output logic [fbrc_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fbrc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fbrc_pkg::CFG_W-1:0]          csr_data
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (OCC_W > fbrc_pkg::CFG_W) ? OCC_W : fbrc_pkg::CFG_W;
   localparam int KEY_W = fbrc_pkg::KEY_W;
   localparam int FD_W  = fbrc_pkg::FD_W;
   localparam int BN_W  = fbrc_pkg::BN_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // memories
   logic [KEY_W-1:0]      key_mem   [ENTRIES];
   logic [COUNT_BITS-1:0] count_mem [ENTRIES];
   logic [IDX_W-1:0]      order_mem [ENTRIES];

   logic [KEY_W-1:0]      key_rd_ff;
   logic [COUNT_BITS-1:0] count_rd_ff;
   logic [IDX_W-1:0]      order_rd_ff;

   // memory ports
   logic                  kc_we;
   logic [IDX_W-1:0]      kc_waddr;
   logic [KEY_W-1:0]      key_wdata;
   logic [COUNT_BITS-1:0] count_wdata;
   logic                  key_we;
   logic [IDX_W-1:0]      kc_raddr;
   logic                  ord_we;
   logic [IDX_W-1:0]      ord_waddr;
   logic [IDX_W-1:0]      ord_wdata;
   logic [IDX_W-1:0]      ord_raddr;

   // control / datapath registers
   fbrc_pkg::state_type   state_ff, state_in;
   logic [OCC_W-1:0]      occ_ff, occ_in;
   logic [OCC_W-1:0]      pos_ff, pos_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic                  hit_ff, hit_in;
   logic                  ev_ff, ev_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [OCC_W-1:0]      best_pos_ff, best_pos_in;
   logic [IDX_W-1:0]      best_slot_ff, best_slot_in;
   logic [COUNT_BITS-1:0] best_cnt_ff, best_cnt_in;
   logic [KEY_W-1:0]      best_key_ff, best_key_in;
   logic [fbrc_pkg::CFG_W-1:0] new_size_ff, old_size_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;
   logic [fbrc_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [fbrc_pkg::RSP_USER_W-1:0] rsp_user_ff;

   logic [CMP_W-1:0]      occ_x, pos_x, new_x, old_x, lim;
   logic                  full;
   logic                  in_new;
   logic [OCC_W-1:0]      pos_nx;
   logic [OCC_W-1:0]      occ_m1;
   logic [IDX_W+3:0]      slot_ext;
   logic [KEY_W-1:0]      ev_key;

   assign occ_x  = CMP_W'(occ_ff);
   assign pos_x  = CMP_W'(pos_ff);
   assign new_x  = CMP_W'(new_size_ff);
   assign old_x  = CMP_W'(old_size_ff);
   assign full   = (occ_ff == OCC_W'(ENTRIES));
   assign pos_nx = pos_ff + OCC_W'(1);
   assign occ_m1 = occ_ff - OCC_W'(1);

   // eviction window: zero means one, clamp to occupancy
   always_comb begin
      lim = (old_x == '0) ? CMP_W'(1) : old_x;
      if (lim > occ_x) lim = occ_x;
   end

   assign in_new = (new_x >= occ_x) || (pos_x >= occ_x - new_x);

   // memories
   always_ff @(posedge clock) begin
      if (kc_we) begin
         if (key_we) key_mem[kc_waddr] <= key_wdata;
         count_mem[kc_waddr] <= count_wdata;
      end
      key_rd_ff   <= key_mem[kc_raddr];
      count_rd_ff <= count_mem[kc_raddr];
   end

   always_ff @(posedge clock) begin
      if (ord_we) order_mem[ord_waddr] <= ord_wdata;
      order_rd_ff <= order_mem[ord_raddr];
   end

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         new_size_ff <= fbrc_pkg::NEW_SECTION_RESET;
         old_size_ff <= fbrc_pkg::OLD_SECTION_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            fbrc_pkg::CSR_NEW_SECTION: new_size_ff <= csr_data;
            fbrc_pkg::CSR_OLD_SECTION: old_size_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      slot_in      = slot_ff;
      hit_in       = hit_ff;
      ev_in        = ev_ff;
      cnt_in       = cnt_ff;
      best_pos_in  = best_pos_ff;
      best_slot_in = best_slot_ff;
      best_cnt_in  = best_cnt_ff;
      best_key_in  = best_key_ff;
      rsp_load     = 1'b0;
      req_tready   = 1'b0;

      kc_we       = 1'b0;
      key_we      = 1'b0;
      kc_waddr    = slot_ff;
      key_wdata   = key_ff;
      count_wdata = COUNT_BITS'(1);
      kc_raddr    = order_rd_ff;
      ord_we      = 1'b0;
      ord_waddr   = pos_ff[IDX_W-1:0];
      ord_wdata   = order_rd_ff;
      ord_raddr   = pos_ff[IDX_W-1:0];

      case (state_ff)
         fbrc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               key_in   = {req_tdata[FD_W-1:0], req_tdata[FD_W+BN_W-1:FD_W]};
               pos_in   = '0;
               hit_in   = 1'b0;
               ev_in    = 1'b0;
               state_in = fbrc_pkg::ST_ORD;
            end
         end
         fbrc_pkg::ST_ORD: begin
            if (pos_ff == occ_ff) state_in = fbrc_pkg::ST_DEC;
            else                  state_in = fbrc_pkg::ST_KEY;
         end
         fbrc_pkg::ST_KEY: begin
            slot_in  = order_rd_ff;
            state_in = fbrc_pkg::ST_CMP;
         end
         fbrc_pkg::ST_CMP: begin
            // strict less keeps ties on the least recent entry
            if (pos_ff == '0 || (pos_x < lim && count_rd_ff < best_cnt_ff)) begin
               best_pos_in  = pos_ff;
               best_slot_in = slot_ff;
               best_cnt_in  = count_rd_ff;
               best_key_in  = key_rd_ff;
            end
            if (key_rd_ff == key_ff) begin
               hit_in   = 1'b1;
               cnt_in   = count_rd_ff;
               state_in = fbrc_pkg::ST_DEC;
            end else begin
               pos_in   = pos_nx;
               state_in = fbrc_pkg::ST_ORD;
            end
         end
         fbrc_pkg::ST_DEC: begin
            if (hit_ff) begin
               if (!in_new && cnt_ff != COUNT_MAX) begin
                  kc_we       = 1'b1;
                  kc_waddr    = slot_ff;
                  count_wdata = cnt_ff + COUNT_BITS'(1);
               end
               state_in = fbrc_pkg::ST_SH_RD;
            end else if (full) begin
               kc_we     = 1'b1;
               key_we    = 1'b1;
               kc_waddr  = best_slot_ff;
               slot_in   = best_slot_ff;
               pos_in    = best_pos_ff;
               ev_in     = 1'b1;
               state_in  = fbrc_pkg::ST_SH_RD;
            end else begin
               kc_we     = 1'b1;
               key_we    = 1'b1;
               kc_waddr  = occ_ff[IDX_W-1:0];
               ord_we    = 1'b1;
               ord_waddr = occ_ff[IDX_W-1:0];
               ord_wdata = occ_ff[IDX_W-1:0];
               slot_in   = occ_ff[IDX_W-1:0];
               occ_in    = occ_ff + OCC_W'(1);
               state_in  = fbrc_pkg::ST_OUT;
            end
         end
         fbrc_pkg::ST_SH_RD: begin
            ord_raddr = pos_nx[IDX_W-1:0];
            if (pos_nx < occ_ff) state_in = fbrc_pkg::ST_SH_WR;
            else                 state_in = fbrc_pkg::ST_TAIL;
         end
         fbrc_pkg::ST_SH_WR: begin
            ord_we    = 1'b1;
            ord_waddr = pos_ff[IDX_W-1:0];
            ord_wdata = order_rd_ff;
            pos_in    = pos_nx;
            state_in  = fbrc_pkg::ST_SH_RD;
         end
         fbrc_pkg::ST_TAIL: begin
            ord_we    = 1'b1;
            ord_waddr = occ_m1[IDX_W-1:0];
            ord_wdata = slot_ff;
            state_in  = fbrc_pkg::ST_OUT;
         end
         fbrc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = fbrc_pkg::ST_IDLE;
            end
         end
         default: state_in = fbrc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbrc_pkg::ST_IDLE;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      key_ff       <= key_in;
      slot_ff      <= slot_in;
      hit_ff       <= hit_in;
      ev_ff        <= ev_in;
      cnt_ff       <= cnt_in;
      best_pos_ff  <= best_pos_in;
      best_slot_ff <= best_slot_in;
      best_cnt_ff  <= best_cnt_in;
      best_key_ff  <= best_key_in;
   end

   // output register
   assign slot_ext = {4'b0, slot_ff};
   assign ev_key   = ev_ff ? best_key_ff : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load)        rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {5'b0, ev_key[BN_W-1:0], ev_key[KEY_W-1:BN_W], slot_ext[3:0]};
         rsp_user_ff <= {ev_ff, hit_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for frequency_based_cache_replacement_core
// Sends block accesses drawn mostly from a small key pool so that hits and
// evictions occur. Each accepted access runs through a directory predictor
// in the scoreboard, and every result is checked field by field. The
// section sizes are changed between phases, only while the block is idle.
// ---------------------------------------------------------------------------
typedef struct packed {
   logic                        hit;
   logic [fbrc_pkg::SLOT_W-1:0] slot;
   logic                        evicted;
   logic [fbrc_pkg::FD_W-1:0]   ev_fd;
   logic [fbrc_pkg::BN_W-1:0]   ev_bn;
} access_result_type;

class directory_scoreboard;
   localparam int N         = fbrc_pkg::ENTRIES_DEFAULT;
   localparam int COUNT_MAX = (1 << fbrc_pkg::COUNT_BITS_DEFAULT) - 1;

   logic [fbrc_pkg::KEY_W-1:0] keys[N];
   int                         counts[N];
   int                         order[N];
   int                         occupied;
   int                         new_size;
   int                         old_size;
   access_result_type          pending[$];
   int                         errors;

   function new();
      occupied = 0;
      new_size = fbrc_pkg::NEW_SECTION_RESET;
      old_size = fbrc_pkg::OLD_SECTION_RESET;
      errors   = 0;
   endfunction

   function void set_section(logic [fbrc_pkg::CSR_INDEX_W-1:0] idx,
                             logic [fbrc_pkg::CFG_W-1:0] value);
      if (idx == fbrc_pkg::CSR_NEW_SECTION) new_size = value;
      else old_size = value;
   endfunction

   function void promote(int pos, int s);
      for (int i = pos; i + 1 < occupied; i++) order[i] = order[i+1];
      order[occupied-1] = s;
   endfunction

   function void note_access(logic [fbrc_pkg::FD_W-1:0] fd, logic [fbrc_pkg::BN_W-1:0] bn);
      logic [fbrc_pkg::KEY_W-1:0] key;
      access_result_type          r;
      int                         pos;
      int                         s;
      int                         lim;
      int                         victim;
      key = {fd, bn};
      r   = '0;
      pos = occupied;
      for (int i = 0; i < occupied; i++)
         if (keys[order[i]] == key) begin
            pos = i;
            break;
         end
      if (pos < occupied) begin
         s = order[pos];
         // counting only outside the new section
         if (!(new_size >= occupied || pos >= occupied - new_size) && counts[s] < COUNT_MAX)
            counts[s]++;
         promote(pos, s);
         r.hit = 1'b1;
      end else begin
         if (occupied >= N) begin
            lim = (old_size == 0) ? 1 : old_size;
            if (lim > occupied) lim = occupied;
            victim = 0;
            for (int i = 1; i < lim; i++)
               if (counts[order[i]] < counts[order[victim]]) victim = i;
            s         = order[victim];
            r.evicted = 1'b1;
            r.ev_fd   = keys[s][fbrc_pkg::KEY_W-1:fbrc_pkg::BN_W];
            r.ev_bn   = keys[s][fbrc_pkg::BN_W-1:0];
            promote(victim, s);
         end else begin
            s = occupied;
            order[occupied] = s;
            occupied++;
         end
         keys[s]   = key;
         counts[s] = 1;
      end
      r.slot = fbrc_pkg::SLOT_W'(s);
      pending.insert(pending.size(), r);
   endfunction

   function void check_result(logic [fbrc_pkg::RSP_DATA_W-1:0] data,
                              logic [fbrc_pkg::RSP_USER_W-1:0] user);
      access_result_type e;
      if (pending.size() == 0) begin
         $error("result with no access outstanding: tdata=%h tuser=%b", data, user);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (user[0] !== e.hit) begin
         $error("hit: expected %0d, got %0d", e.hit, user[0]);
         errors++;
      end
      if (data[3:0] !== e.slot) begin
         $error("slot: expected %0d, got %0d", e.slot, data[3:0]);
         errors++;
      end
      if (user[1] !== e.evicted) begin
         $error("evicted: expected %0d, got %0d", e.evicted, user[1]);
         errors++;
      end
      if (data[19:4] !== e.ev_fd) begin
         $error("evicted_descriptor: expected %h, got %h", e.ev_fd, data[19:4]);
         errors++;
      end
      if (data[50:20] !== e.ev_bn) begin
         $error("evicted_block: expected %h, got %h", e.ev_bn, data[50:20]);
         errors++;
      end
   endfunction
endclass

module tb;
   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [fbrc_pkg::REQ_DATA_W-1:0]  req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [fbrc_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic [fbrc_pkg::RSP_USER_W-1:0]  rsp_tuser;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [fbrc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [fbrc_pkg::CFG_W-1:0]       csr_data;

   directory_scoreboard sb = new();
   logic [fbrc_pkg::FD_W-1:0] pool_fd[24];
   logic [fbrc_pkg::BN_W-1:0] pool_bn[24];
   bit                        quiet;
   int                        stall_left;

   frequency_based_cache_replacement_core DUT (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("FAILURE");
      $finish;
   end

   // receiver: random stall bursts, checks every transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_access(logic [fbrc_pkg::FD_W-1:0] fd, logic [fbrc_pkg::BN_W-1:0] bn);
      req_tdata  <= {1'b0, bn, fd};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_access(fd, bn);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_section(logic [fbrc_pkg::CSR_INDEX_W-1:0] idx,
                                logic [fbrc_pkg::CFG_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.set_section(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_accesses(int n);
      int k;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            send_access(fbrc_pkg::FD_W'($urandom), fbrc_pkg::BN_W'($urandom));
         end else begin
            k = $urandom_range(0, 23);
            send_access(pool_fd[k], pool_bn[k]);
         end
      end
   endtask

   initial begin
      logic [fbrc_pkg::CFG_W-1:0] new_sizes[8] = '{0, 16, 1, 16, 0, 2, 4, 31};
      logic [fbrc_pkg::CFG_W-1:0] old_sizes[8] = '{0, 16, 1, 1, 16, 31, 8, 3};
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = fbrc_pkg::CSR_NEW_SECTION;
      csr_data   = '0;
      quiet      = 1'b0;
      reset      = 1'b1;
      for (int i = 0; i < 24; i++) begin
         pool_fd[i] = (i < 8) ? 16'(i % 3) : 16'($urandom);
         pool_bn[i] = fbrc_pkg::BN_W'($urandom);
      end
      pool_fd[0] = '0;          pool_bn[0] = '0;
      pool_fd[1] = '1;          pool_bn[1] = '1;
      pool_fd[2] = '0;          pool_bn[2] = '1;
      pool_fd[3] = '1;          pool_bn[3] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fill the directory, hit old and new entries, then evict
      for (int i = 0; i < 16; i++) send_access(pool_fd[i], pool_bn[i]);
      send_access(pool_fd[0], pool_bn[0]);    // old section hit raises count
      send_access(pool_fd[15], pool_bn[15]);  // new section hit, no count
      send_access(pool_fd[0], pool_bn[0]);
      send_access(pool_fd[1], pool_bn[1]);
      send_access(16'h8000, 31'h4000_0000);   // miss on full directory
      send_access(16'h7fff, 31'h3fff_ffff);
      send_access(pool_fd[16], pool_bn[16]);
      drain();

      for (int p = 0; p < 8; p++) begin
         write_section(fbrc_pkg::CSR_NEW_SECTION, new_sizes[p]);
         write_section(fbrc_pkg::CSR_OLD_SECTION, old_sizes[p]);
         if (p == 7) quiet = 1'b1;
         random_accesses(52);
         drain();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

>>> sim.f
rtl/core/fbrc_pkg.sv
rtl/core/frequency_based_cache_replacement_core.sv
tb/tb.sv
